// ===== src/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg: shared types for the strongly connected components core
// Request codes, datapath operations, command/status bundles and result word.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  localparam int unsigned VERTEX_COUNT_RESET = 64;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LD_WRITE,
    OP_LD_LINK,
    OP_RUN_INIT,
    OP_NEXT_ROOT,
    OP_VISIT_ROOT,
    OP_VISIT_EDGE,
    OP_LOAD_HEAD,
    OP_READ_EDGE,
    OP_EDGE_ADV,
    OP_LOW_MIN,
    OP_POP_READ,
    OP_EMIT,
    OP_RET_TOP,
    OP_RET_READ,
    OP_RET_LOAD,
    OP_FINISH
  } scc_op_e;

  typedef struct packed {
    scc_op_e op;
  } scc_cmd_t;

  typedef struct packed {
    logic edge_ok;      // latched edge is in range and the store has room
    logic root_done;    // root scan reached the vertex count
    logic root_visited; // current root already visited
    logic link_nz;      // current frame has an edge left
    logic is_head;      // low link equals visit order
    logic w_skip;       // edge target beyond the vertex count
    logic w_unvisited;
    logic w_onstack;
    logic pop_last;     // popped vertex closes the component
    logic emit_ok;      // result staging can take a word
    logic call_one;     // only the current frame is on the call stack
  } scc_stat_t;

  typedef struct packed {
    logic [6:0] vertex_id;
    logic [5:0] component_number;
    logic       last_in_component;
    logic       last_of_run;
  } scc_res_t;

endpackage

// ===== src/scc_if.sv =====
// ----------------------------------------------------------------------------
// scc_if: handshake channels of the strongly connected components core
// Request, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface scc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [6:0] edge_from;
  logic [6:0] edge_to;

  modport source (output valid, req_type, edge_from, edge_to, input ready);
  modport sink   (input valid, req_type, edge_from, edge_to, output ready);
endinterface

interface scc_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] vertex_id;
  logic [5:0] component_number;
  logic       last_in_component;
  logic       last_of_run;

  modport source (output valid, vertex_id, component_number, last_in_component,
                  last_of_run, input ready);
  modport sink   (input valid, vertex_id, component_number, last_in_component,
                  last_of_run, output ready);
endinterface

interface scc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

// ===== src/scc_ram.sv =====
// ----------------------------------------------------------------------------
// scc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                         wdata_i,
  input  logic                                 re_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl: sequencer of the strongly connected components core
// Walks edge loads and the depth-first search, one operation per cycle unless result staging stalls it.
// ----------------------------------------------------------------------------
module scc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic                run_i,
  input  scc_pkg::scc_stat_t  stat_i,
  output scc_pkg::scc_cmd_t   cmd_o,
  output logic                in_ready_o
);
  import scc_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LD0   = 14'b00000000000010,
    S_LD1   = 14'b00000000000100,
    S_RINIT = 14'b00000000001000,
    S_ROOT  = 14'b00000000010000,
    S_VHEAD = 14'b00000000100000,
    S_STEP  = 14'b00000001000000,
    S_EDGE  = 14'b00000010000000,
    S_CMP   = 14'b00000100000000,
    S_POP   = 14'b00001000000000,
    S_POP2  = 14'b00010000000000,
    S_RET   = 14'b00100000000000,
    S_RET2  = 14'b01000000000000,
    S_FLUSH = 14'b10000000000000
  } state_e;

  state_e  state_q, state_d;
  scc_op_e op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (acc_i) begin
          state_d = (run_i == REQ_RUN) ? S_RINIT : S_LD0;
        end
      end
      S_LD0: begin
        op      = OP_LD_WRITE;
        state_d = stat_i.edge_ok ? S_LD1 : S_IDLE;
      end
      S_LD1: begin
        op      = OP_LD_LINK;
        state_d = S_IDLE;
      end
      S_RINIT: begin
        op      = OP_RUN_INIT;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (stat_i.root_done) begin
          state_d = S_FLUSH;
        end else if (stat_i.root_visited) begin
          op = OP_NEXT_ROOT;
        end else begin
          op      = OP_VISIT_ROOT;
          state_d = S_VHEAD;
        end
      end
      S_VHEAD: begin
        op      = OP_LOAD_HEAD;
        state_d = S_STEP;
      end
      S_STEP: begin
        if (stat_i.link_nz) begin
          op      = OP_READ_EDGE;
          state_d = S_EDGE;
        end else begin
          state_d = stat_i.is_head ? S_POP : S_RET;
        end
      end
      S_EDGE: begin
        if (stat_i.w_skip) begin
          op      = OP_EDGE_ADV;
          state_d = S_STEP;
        end else if (stat_i.w_unvisited) begin
          op      = OP_VISIT_EDGE;
          state_d = S_VHEAD;
        end else begin
          op      = OP_EDGE_ADV;
          state_d = stat_i.w_onstack ? S_CMP : S_STEP;
        end
      end
      S_CMP: begin
        op      = OP_LOW_MIN;
        state_d = S_STEP;
      end
      S_POP: begin
        op      = OP_POP_READ;
        state_d = S_POP2;
      end
      S_POP2: begin
        if (stat_i.emit_ok) begin
          op      = OP_EMIT;
          state_d = stat_i.pop_last ? S_RET : S_POP;
        end
      end
      S_RET: begin
        if (stat_i.call_one) begin
          op      = OP_RET_TOP;
          state_d = S_ROOT;
        end else begin
          op      = OP_RET_READ;
          state_d = S_RET2;
        end
      end
      S_RET2: begin
        op      = OP_RET_LOAD;
        state_d = S_STEP;
      end
      S_FLUSH: begin
        if (stat_i.emit_ok) begin
          op      = OP_FINISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.op   = op;
  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== src/scc_dpath.sv =====
// ----------------------------------------------------------------------------
// scc_dpath: datapath of the strongly connected components core
// Edge store, adjacency lists, search stacks, flags and result staging.
// ----------------------------------------------------------------------------
module scc_dpath #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scc_pkg::scc_cmd_t  cmd_i,
  output scc_pkg::scc_stat_t stat_o,
  input  logic               acc_i,
  input  logic [6:0]         from_i,
  input  logic [6:0]         to_i,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output scc_pkg::scc_res_t  out_o
);
  import scc_pkg::*;

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [EW-1:0] link;
    logic [VW-1:0] low;
    logic [VW-1:0] ord;
  } frame_t;

  localparam int unsigned FW = $bits(frame_t);

  scc_op_e op;
  assign op = cmd_i.op;

  logic [6:0]              vc_q, from_q, to_q;
  logic [EW-1:0]           ecnt_q;
  logic [MAX_VERTICES-1:0] hv_q, visited_q, onstk_q;
  logic [VW-1:0]           cnt_q, comp_q;
  logic [NW-1:0]           r_q, csp_q, ksp_q;
  logic [VW-1:0]           cur_v_q, cur_low_q, cur_ord_q;
  logic [EW-1:0]           cur_link_q;
  logic                    hvx_q;
  scc_res_t                pend_q, out_q;
  logic                    pend_v_q, out_v_q;

  logic [NW-1:0] nn;
  logic [VW-1:0] s, t, x;
  logic          edge_ok, out_ok, emit_ok, visit, load_out;
  logic [EW-1:0] slot1;

  logic [VW-1:0] tgt_q, ord_q, cstk_q;
  logic [EW-1:0] nxt_q, head_q, tail_q;
  frame_t        frame_q, frame_w;
  logic [FW-1:0] frame_rd;

  // effective vertex count
  always_comb begin
    if (int'(vc_q) > int'(MAX_VERTICES)) begin
      nn = NW'(MAX_VERTICES);
    end else begin
      nn = NW'(vc_q);
    end
  end

  assign s       = VW'(from_q - 7'd1);
  assign t       = VW'(to_q - 7'd1);
  assign edge_ok = (from_q != 7'd0) && (to_q != 7'd0) &&
                   (int'(from_q) <= int'(nn)) && (int'(to_q) <= int'(nn)) &&
                   (int'(ecnt_q) < int'(MAX_EDGES));
  assign slot1   = EW'(ecnt_q + EW'(1));
  assign visit   = (op == OP_VISIT_ROOT) || (op == OP_VISIT_EDGE);
  assign x       = (op == OP_VISIT_ROOT) ? VW'(r_q) : tgt_q;
  assign out_ok  = !out_v_q || out_ready_i;
  assign emit_ok = !pend_v_q || out_ok;
  assign frame_q = frame_t'(frame_rd);

  assign frame_w.v    = cur_v_q;
  assign frame_w.link = nxt_q;
  assign frame_w.low  = cur_low_q;
  assign frame_w.ord  = cur_ord_q;

  // edge store
  scc_ram #(.W(VW), .D(MAX_EDGES)) u_tgt (
    .clk_i, .we_i((op == OP_LD_WRITE) && edge_ok), .waddr_i(AW'(ecnt_q)),
    .wdata_i(t), .re_i(op == OP_READ_EDGE), .raddr_i(AW'(cur_link_q - EW'(1))),
    .rdata_o(tgt_q)
  );

  scc_ram #(.W(EW), .D(MAX_EDGES)) u_nxt (
    .clk_i,
    .we_i(((op == OP_LD_WRITE) && edge_ok) || ((op == OP_LD_LINK) && hv_q[s])),
    .waddr_i((op == OP_LD_LINK) ? AW'(tail_q - EW'(1)) : AW'(ecnt_q)),
    .wdata_i((op == OP_LD_LINK) ? slot1 : '0),
    .re_i(op == OP_READ_EDGE), .raddr_i(AW'(cur_link_q - EW'(1))),
    .rdata_o(nxt_q)
  );

  // adjacency list ends
  scc_ram #(.W(EW), .D(MAX_VERTICES)) u_head (
    .clk_i, .we_i((op == OP_LD_LINK) && !hv_q[s]), .waddr_i(s), .wdata_i(slot1),
    .re_i(visit), .raddr_i(x), .rdata_o(head_q)
  );

  scc_ram #(.W(EW), .D(MAX_VERTICES)) u_tail (
    .clk_i, .we_i(op == OP_LD_LINK), .waddr_i(s), .wdata_i(slot1),
    .re_i(op == OP_LD_WRITE), .raddr_i(s), .rdata_o(tail_q)
  );

  // search state
  scc_ram #(.W(VW), .D(MAX_VERTICES)) u_ord (
    .clk_i, .we_i(visit), .waddr_i(x), .wdata_i(cnt_q),
    .re_i(op == OP_EDGE_ADV), .raddr_i(tgt_q), .rdata_o(ord_q)
  );

  scc_ram #(.W(VW), .D(MAX_VERTICES)) u_cstk (
    .clk_i, .we_i(visit), .waddr_i(VW'(csp_q)), .wdata_i(x),
    .re_i(op == OP_POP_READ), .raddr_i(VW'(csp_q - NW'(1))), .rdata_o(cstk_q)
  );

  scc_ram #(.W(FW), .D(MAX_VERTICES)) u_call (
    .clk_i, .we_i(visit && (ksp_q != '0)), .waddr_i(VW'(ksp_q - NW'(1))),
    .wdata_i(frame_w), .re_i(op == OP_RET_READ),
    .raddr_i(VW'(ksp_q - NW'(2))), .rdata_o(frame_rd)
  );

  assign load_out = ((op == OP_EMIT) && pend_v_q) || ((op == OP_FINISH) && pend_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q      <= 7'(VERTEX_COUNT_RESET);
      ecnt_q    <= '0;
      hv_q      <= '0;
      visited_q <= '0;
      onstk_q   <= '0;
      cnt_q     <= '0;
      comp_q    <= '0;
      r_q       <= '0;
      csp_q     <= '0;
      ksp_q     <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_data_i;
      end
      out_v_q <= (out_v_q && !out_ready_i) || load_out;
      case (op)
        OP_LD_LINK: begin
          ecnt_q  <= slot1;
          hv_q[s] <= 1'b1;
        end
        OP_RUN_INIT: begin
          visited_q <= '0;
          onstk_q   <= '0;
          cnt_q     <= '0;
          comp_q    <= '0;
          r_q       <= '0;
          csp_q     <= '0;
          ksp_q     <= '0;
        end
        OP_NEXT_ROOT: r_q <= r_q + NW'(1);
        OP_VISIT_ROOT, OP_VISIT_EDGE: begin
          visited_q[x] <= 1'b1;
          onstk_q[x]   <= 1'b1;
          cnt_q        <= cnt_q + VW'(1);
          csp_q        <= csp_q + NW'(1);
          ksp_q        <= ksp_q + NW'(1);
          if (op == OP_VISIT_ROOT) begin
            r_q <= r_q + NW'(1);
          end
        end
        OP_POP_READ: csp_q <= csp_q - NW'(1);
        OP_EMIT: begin
          onstk_q[cstk_q] <= 1'b0;
          pend_v_q        <= 1'b1;
          if (cstk_q == cur_v_q) begin
            comp_q <= comp_q + VW'(1);
          end
        end
        OP_RET_TOP:  ksp_q <= '0;
        OP_RET_READ: ksp_q <= ksp_q - NW'(1);
        OP_FINISH: begin
          pend_v_q <= 1'b0;
          hv_q     <= '0;
          ecnt_q   <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      from_q <= from_i;
      to_q   <= to_i;
    end
    if (load_out) begin
      // the staged word is the final one when the run finishes
      out_q <= '{vertex_id:         pend_q.vertex_id,
                 component_number:  pend_q.component_number,
                 last_in_component: pend_q.last_in_component,
                 last_of_run:       (op == OP_FINISH)};
    end
    case (op)
      OP_VISIT_ROOT, OP_VISIT_EDGE: begin
        cur_v_q   <= x;
        cur_low_q <= cnt_q;
        cur_ord_q <= cnt_q;
        hvx_q     <= hv_q[x];
      end
      OP_LOAD_HEAD: cur_link_q <= hvx_q ? head_q : '0;
      OP_EDGE_ADV:  cur_link_q <= nxt_q;
      OP_LOW_MIN: begin
        if (ord_q < cur_low_q) begin
          cur_low_q <= ord_q;
        end
      end
      OP_EMIT: begin
        pend_q.vertex_id         <= 7'(int'(cstk_q) + 1);
        pend_q.component_number  <= 6'(comp_q);
        pend_q.last_in_component <= (cstk_q == cur_v_q);
        pend_q.last_of_run       <= 1'b0;
      end
      OP_RET_LOAD: begin
        cur_v_q    <= frame_q.v;
        cur_link_q <= frame_q.link;
        cur_ord_q  <= frame_q.ord;
        cur_low_q  <= (cur_low_q < frame_q.low) ? cur_low_q : frame_q.low;
      end
      default: ;
    endcase
  end

  assign stat_o.edge_ok      = edge_ok;
  assign stat_o.root_done    = (r_q >= nn);
  assign stat_o.root_visited = visited_q[VW'(r_q)];
  assign stat_o.link_nz      = (cur_link_q != '0);
  assign stat_o.is_head      = (cur_low_q == cur_ord_q);
  assign stat_o.w_skip       = (int'(tgt_q) >= int'(nn));
  assign stat_o.w_unvisited  = !visited_q[tgt_q];
  assign stat_o.w_onstack    = onstk_q[tgt_q];
  assign stat_o.pop_last     = (cstk_q == cur_v_q);
  assign stat_o.emit_ok      = emit_ok;
  assign stat_o.call_one     = (ksp_q == NW'(1));

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

// ===== src/strongly_connected_components_core.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components_core: Tarjan SCC engine over a loaded graph
// Usage:
//  - req_i carries one word per request. req_type 0 loads a directed edge
//    (edge_from -> edge_to, 1-based); it is dropped when a vertex is out of
//    range or the edge store is full. req_type 1 runs the search.
//  - res_o returns one word per vertex on a run: components in completion
//    order, vertices in pop order, last_in_component closing each component
//    and last_of_run on the final word. A run with no vertices returns none.
//  - cfg_i writes vertex_count; it is always ready and is meant to be
//    written only while the core is idle.
//  - An edge load passes through S_LD0 and S_LD1 from accept to the next ready
//    (S_LD0 only when it is dropped). A run spends separate sequencer steps on
//    each edge walked and on each vertex's visit, pop and return, set by the one
//    read port of each store.
//  - One word is staged ahead of the output register; a stalled receiver
//    stalls the search only when both hold a word.
//  - Reset empties the edge store and sets vertex_count to 64; there is no
//    clearing pass. The edge store empties again after each run.
// ----------------------------------------------------------------------------
module strongly_connected_components_core #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scc_req_if.sink   req_i,
  scc_res_if.source res_o,
  scc_cfg_if.sink   cfg_i
);
  import scc_pkg::*;

  scc_cmd_t  cmd;
  scc_stat_t stat;
  scc_res_t  res;
  logic      in_ready;
  logic      acc;

  assign req_i.ready = in_ready;
  assign acc         = req_i.valid && in_ready;
  assign cfg_i.ready = 1'b1;

  // sequencer
  scc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .acc_i      (acc),
    .run_i      (req_i.req_type),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  // stores, stacks and result staging
  scc_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .stat_o      (stat),
    .acc_i       (acc),
    .from_i      (req_i.edge_from),
    .to_i        (req_i.edge_to),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.vertex_count),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .out_o       (res)
  );

  assign res_o.vertex_id         = res.vertex_id;
  assign res_o.component_number  = res.component_number;
  assign res_o.last_in_component = res.last_in_component;
  assign res_o.last_of_run       = res.last_of_run;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the strongly connected components core
// Loads random and directed graphs as edge words, runs the search and checks
// every component word against a local Tarjan predictor. Covers vertex-count
// extremes, a full edge store, dropped edges, a shrunk count after loading
// and a long receiver hold-off that fills the core.
// ----------------------------------------------------------------------------
module tb;
  import scc_pkg::*;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam int WATCHDOG = 20000;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic       req_type;
    logic [6:0] edge_from;
    logic [6:0] edge_to;
  } req_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  scc_req_if req();
  scc_res_if res();
  scc_cfg_if cfg();

  strongly_connected_components_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req.sink), .res_o(res.source), .cfg_i(cfg.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int        vcount = VERTEX_COUNT_RESET;
  int        e_tgt[NE];
  int        e_nxt[NE];
  int        a_head[NV];
  int        a_tail[NV];
  int        e_cnt = 0;
  scc_res_t  comp_words_q[$];

  function automatic void predict_load(int from, int to);
    int n;
    int s;
    n = (vcount > NV) ? NV : vcount;
    if (from == 0 || to == 0 || from > n || to > n || e_cnt >= NE) return;
    s = from - 1;
    e_tgt[e_cnt] = to - 1;
    e_nxt[e_cnt] = 0;
    if (a_head[s] == 0) a_head[s] = e_cnt + 1;
    else e_nxt[a_tail[s] - 1] = e_cnt + 1;
    a_tail[s] = e_cnt + 1;
    e_cnt++;
  endfunction

  function automatic void predict_run();
    int n, cnt, comp, cnt0, vc, csp, ssp, v, lk, w, u;
    bit vis[NV];
    bit ons[NV];
    int ord[NV];
    int low[NV];
    int cstk[NV];
    int fv[NV];
    int fl[NV];
    scc_res_t r;
    n = (vcount > NV) ? NV : vcount;
    cnt = 0; comp = 0; vc = 0; csp = 0; ssp = 0;
    cnt0 = comp_words_q.size();
    for (int i = 0; i < NV; i++) begin
      vis[i] = 0; ons[i] = 0;
    end
    for (int root = 0; root < n; root++) begin
      if (vis[root]) continue;
      vis[root] = 1; ord[root] = vc; low[root] = vc; vc++;
      cstk[csp++] = root; ons[root] = 1;
      fv[ssp] = root; fl[ssp] = a_head[root]; ssp++;
      while (ssp > 0) begin
        v = fv[ssp-1];
        lk = fl[ssp-1];
        if (lk != 0) begin
          w = e_tgt[lk-1];
          fl[ssp-1] = e_nxt[lk-1];
          if (w >= n) continue;
          if (!vis[w]) begin
            vis[w] = 1; ord[w] = vc; low[w] = vc; vc++;
            cstk[csp++] = w; ons[w] = 1;
            fv[ssp] = w; fl[ssp] = a_head[w]; ssp++;
          end else if (ons[w] && ord[w] < low[v]) low[v] = ord[w];
          continue;
        end
        if (low[v] == ord[v]) begin
          do begin
            w = cstk[--csp];
            ons[w] = 0;
            r.vertex_id = 7'(w + 1);
            r.component_number = 6'(comp);
            r.last_in_component = (w == v);
            r.last_of_run = 1'b0;
            comp_words_q.push_back(r);
            cnt++;
          end while (w != v);
          comp++;
        end
        ssp--;
        if (ssp > 0) begin
          u = fv[ssp-1];
          if (low[v] < low[u]) low[u] = low[v];
        end
      end
    end
    if (cnt > 0) comp_words_q[cnt0 + cnt - 1].last_of_run = 1'b1;
    for (int i = 0; i < NV; i++) begin
      a_head[i] = 0; a_tail[i] = 0;
    end
    e_cnt = 0;
  endfunction

  // stimulus
  req_word_t pending_q[$];
  bit        fail = 0;
  bit        calm = 0;     // last part of the run: no idling
  bit        hold_go = 0;
  bit        hold_on = 0;
  int        quiet = 0;

  // receiver hold-off, counted in its own process
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // driver: each accepted word is predicted at its accept edge
  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.req_type <= REQ_LOAD;
      req.edge_from <= '0;
      req.edge_to <= '0;
    end else begin
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_RUN) predict_run();
        else predict_load(req.edge_from, req.edge_to);
        void'(pending_q.pop_front());
      end
      if (!(req.valid && !req.ready)) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          req.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(0, 3);
          req.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req.valid <= 1'b1;
          {req.req_type, req.edge_from, req.edge_to} <= pending_q[0];
        end else req.valid <= 1'b0;
      end
    end
  end

  // monitor: compares each result word with the oldest expectation
  int snk_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (comp_words_q.size() == 0) begin
          $error("unexpected result word vertex_id=%0d", res.vertex_id);
          fail = 1;
        end else begin
          scc_res_t e;
          e = comp_words_q.pop_front();
          if (res.vertex_id !== e.vertex_id) begin
            $error("vertex_id exp %0d got %0d", e.vertex_id, res.vertex_id); fail = 1;
          end
          if (res.component_number !== e.component_number) begin
            $error("component_number exp %0d got %0d", e.component_number,
                   res.component_number); fail = 1;
          end
          if (res.last_in_component !== e.last_in_component) begin
            $error("last_in_component exp %0d got %0d", e.last_in_component,
                   res.last_in_component); fail = 1;
          end
          if (res.last_of_run !== e.last_of_run) begin
            $error("last_of_run exp %0d got %0d", e.last_of_run, res.last_of_run); fail = 1;
          end
        end
      end
      if (hold_on) begin
        res.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        res.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        snk_gap <= $urandom_range(0, 3);
        res.ready <= 1'b0;
      end else res.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready) || !rst_ni) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_edge(int from, int to);
    pending_q.push_back({REQ_LOAD, 7'(from), 7'(to)});
  endtask

  task automatic push_run();
    pending_q.push_back({REQ_RUN, 7'($urandom), 7'($urandom)});
  endtask

  // waits for every word to drain, then the core's own tail
  task automatic drain();
    while (pending_q.size() > 0 || comp_words_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_count(int value);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.vertex_count <= 7'(value);
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    vcount = value;
    cfg.valid <= 1'b0;
  endtask

  // random graph: mostly in-range edges, some out of range noise
  task automatic random_graph(int n, int edges);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 9) == 0) push_edge($urandom_range(0, 127), $urandom_range(0, 127));
      else push_edge($urandom_range(1, n), $urandom_range(1, n));
    end
    push_run();
  endtask

  initial begin
    int n;
    cfg.valid = 1'b0;
    cfg.vertex_count = '0;
    for (int i = 0; i < NV; i++) begin
      a_head[i] = 0; a_tail[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: cycle plus a tail at the reset count, extremes of the fields
    push_edge(1, 2); push_edge(2, 3); push_edge(3, 1); push_edge(3, 64);
    push_edge(64, 64); push_edge(0, 5); push_edge(65, 1); push_edge(127, 127);
    push_run();
    push_run();                      // empty graph: each vertex its own component
    drain();

    write_count(1);
    push_edge(1, 1); push_edge(1, 2); push_run();
    drain();
    write_count(0);                  // zero vertices: no words, store still clears
    push_edge(1, 1); push_run();
    drain();
    write_count(127);                // taken as the maximum
    push_edge(64, 1); push_edge(1, 64); push_run();
    drain();

    // count shrunk after loading
    write_count(8);
    push_edge(1, 8); push_edge(8, 1); push_edge(2, 3); push_edge(3, 2);
    drain();
    write_count(3);
    push_run();
    drain();

    // edge store overflow on a long chain
    write_count(64);
    for (int i = 0; i < NE + 2; i++) push_edge((i % 64) + 1, ((i + 1) % 64) + 1);
    push_run();
    drain();

    // receiver hold-off while a large run fills the core
    hold_go = 1;
    random_graph(64, 8);
    random_graph(64, 3);
    drain();

    // random phases, graphs with few edges
    for (int p = 0; p < 3; p++) begin
      n = (p == 1) ? 64 : $urandom_range(2, 12);
      if (p == 2) calm = 1;
      write_count(n);
      random_graph(n, $urandom_range(0, 4));
      random_graph(n, $urandom_range(0, 4));
      drain();
    end

    if (fail == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
